FILE: hw/rtl/fsph_pkg.sv
// ----------------------------------------------------------------------------
// fsph_pkg
// Shared types and constants for the framed sensor parser: request codes,
// result kinds, the command passed from front to back, and ASCII codes.
// ----------------------------------------------------------------------------
package fsph_pkg;

	localparam int VAL_W   = 16;
	localparam int ACC_W   = 17;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;
	localparam int CFG_IDX_W = 1;

	// request codes on the action field
	typedef enum logic [1:0] {
		ACT_BYTE   = 2'd0,
		ACT_TOGGLE = 2'd1,
		ACT_AUTO   = 2'd2
	} action_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ENV    = 2'd0,
		KIND_MANUAL = 2'd1,
		KIND_AUTO   = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DARK   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 1'd1;

	localparam logic signed [VAL_W-1:0] DARK_RESET   = 16'sd20;
	localparam logic signed [VAL_W-1:0] BRIGHT_RESET = 16'sd35;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_V      = 8'h56;

	// command from front to back
	typedef struct packed {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  temp;
		logic signed [VAL_W-1:0]  hum;
		logic signed [VAL_W-1:0]  light;
	} cmd_t;

endpackage

FILE: hw/rtl/fsph_front.sv
// ----------------------------------------------------------------------------
// fsph_front
// Request intake: frames serial bytes, parses the ENV payload one byte per
// accepted cycle and emits commands for completed frames and user events.
// ----------------------------------------------------------------------------
module fsph_front import fsph_pkg::*; #(
	parameter int PAYLOAD_MAX = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	output logic        push,
	output cmd_t        cmd
);

	localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

	typedef enum logic [11:0] {
		PH_E     = 12'b0000_0000_0001,
		PH_N     = 12'b0000_0000_0010,
		PH_V     = 12'b0000_0000_0100,
		PH_C     = 12'b0000_0000_1000,
		PH_PRE1  = 12'b0000_0001_0000,
		PH_BODY1 = 12'b0000_0010_0000,
		PH_PRE2  = 12'b0000_0100_0000,
		PH_BODY2 = 12'b0000_1000_0000,
		PH_PRE3  = 12'b0001_0000_0000,
		PH_BODY3 = 12'b0010_0000_0000,
		PH_DONE  = 12'b0100_0000_0000,
		PH_FAIL  = 12'b1000_0000_0000
	} phase_t;

	logic                    in_frame_q, in_frame_d;
	logic [CNT_W-1:0]        count_q, count_d;
	phase_t                  phase_q, phase_d;
	logic                    neg_q, neg_d;
	logic                    seen_q, seen_d;
	logic [ACC_W-1:0]        acc_q, acc_d;
	logic signed [VAL_W-1:0] ptemp_q, ptemp_d;
	logic signed [VAL_W-1:0] phum_q, phum_d;

	logic       is_digit, is_space;
	logic [3:0] digit;
	logic [19:0] acc_mul;

	function automatic logic [VAL_W-1:0] num_value(input logic n, input logic [ACC_W-1:0] m);
		logic [ACC_W-1:0] t;
		begin
			t = 17'h10000 - m;
			if (n)
				num_value = t[VAL_W-1:0];
			else if (m > 17'd32767)
				num_value = 16'h7FFF;
			else
				num_value = m[VAL_W-1:0];
		end
	endfunction

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign digit    = 4'(rx_byte - CH_ZERO);
	assign acc_mul  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 20'(digit);

	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		seen_d     = seen_q;
		acc_d      = acc_q;
		ptemp_d    = ptemp_q;
		phum_d     = phum_q;
		push       = 1'b0;
		cmd.kind   = KIND_ENV;
		cmd.temp   = ptemp_q;
		cmd.hum    = phum_q;
		cmd.light  = num_value(neg_q, acc_q);

		if (accept) begin
			unique case (action)
				ACT_TOGGLE: begin
					push     = 1'b1;
					cmd.kind = KIND_MANUAL;
				end
				ACT_AUTO: begin
					push     = 1'b1;
					cmd.kind = KIND_AUTO;
				end
				ACT_BYTE: begin
					if (!in_frame_q) begin
						if (rx_byte == CH_DOLLAR) begin
							in_frame_d = 1'b1;
							count_d    = '0;
							phase_d    = PH_E;
							neg_d      = 1'b0;
							seen_d     = 1'b0;
							acc_d      = '0;
						end
					end else if (rx_byte == CH_HASH) begin
						in_frame_d = 1'b0;
						push = (phase_q == PH_DONE) || ((phase_q == PH_BODY3) && seen_q);
					end else if (count_q < CNT_W'(PAYLOAD_MAX)) begin
						count_d = count_q + 1'b1;
						unique case (phase_q)
							PH_E: phase_d = (rx_byte == CH_E) ? PH_N : PH_FAIL;
							PH_N: phase_d = (rx_byte == CH_N) ? PH_V : PH_FAIL;
							PH_V: phase_d = (rx_byte == CH_V) ? PH_C : PH_FAIL;
							PH_C: begin
								if (rx_byte == CH_COMMA) begin
									phase_d = PH_PRE1;
									neg_d   = 1'b0;
									seen_d  = 1'b0;
									acc_d   = '0;
								end else begin
									phase_d = PH_FAIL;
								end
							end
							PH_PRE1, PH_PRE2, PH_PRE3: begin
								if (!is_space) begin
									if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
										neg_d   = (rx_byte == CH_MINUS);
										phase_d = phase_t'({phase_q[10:0], 1'b0});
									end else if (is_digit) begin
										seen_d  = 1'b1;
										acc_d   = ACC_W'(digit);
										phase_d = phase_t'({phase_q[10:0], 1'b0});
									end else begin
										phase_d = PH_FAIL;
									end
								end
							end
							PH_BODY1, PH_BODY2, PH_BODY3: begin
								if (is_digit) begin
									acc_d  = (acc_mul > 20'd32768) ? 17'd32768 : acc_mul[ACC_W-1:0];
									seen_d = 1'b1;
								end else if (!seen_q) begin
									phase_d = PH_FAIL;
								end else if (phase_q == PH_BODY3) begin
									phase_d = PH_DONE;
								end else if (rx_byte != CH_COMMA) begin
									phase_d = PH_FAIL;
								end else begin
									if (phase_q == PH_BODY1)
										ptemp_d = num_value(neg_q, acc_q);
									else
										phum_d = num_value(neg_q, acc_q);
									phase_d = phase_t'({phase_q[10:0], 1'b0});
									neg_d   = 1'b0;
									seen_d  = 1'b0;
									acc_d   = '0;
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			phase_q    <= PH_E;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
			acc_q      <= '0;
			ptemp_q    <= '0;
			phum_q     <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			seen_q     <= seen_d;
			acc_q      <= acc_d;
			ptemp_q    <= ptemp_d;
			phum_q     <= phum_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PAYLOAD_MAX))
		else $error("payload count past limit");

endmodule

FILE: hw/rtl/fsph_queue.sv
// ----------------------------------------------------------------------------
// fsph_queue
// Two-entry command queue between the parser front and the control back.
// ----------------------------------------------------------------------------
module fsph_queue import fsph_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty,
	output logic full
);

	cmd_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   fill_q;

	assign empty  = (fill_q == '0);
	assign full   = (fill_q == (Q_AW+1)'(Q_DEPTH));
	assign rd_cmd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

FILE: hw/rtl/fsph_back.sv
// ----------------------------------------------------------------------------
// fsph_back
// Executes queued commands: stores sensor values, runs the lamp hysteresis
// and manual/auto control, and holds the result in an output register.
// ----------------------------------------------------------------------------
module fsph_back import fsph_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_avail,
	input  cmd_t                    cmd,
	output logic                    pop,
	input  logic signed [VAL_W-1:0] dark_th,
	input  logic signed [VAL_W-1:0] bright_th,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              kind,
	output logic signed [VAL_W-1:0] temperature,
	output logic signed [VAL_W-1:0] humidity,
	output logic signed [VAL_W-1:0] light_level,
	output logic                    lamp_toggle,
	output logic                    night_mode,
	output logic                    auto_mode
);

	logic signed [VAL_W-1:0] temp_q, hum_q, light_q;
	logic signed [VAL_W-1:0] temp_d, hum_d, light_d;
	logic                    auto_q, lamp_q, auto_d, lamp_d, toggle_d;
	logic                    valid_q;
	kind_t                   kind_q;
	logic                    toggle_q;

	assign pop = cmd_avail && (!valid_q || out_ready);

	always_comb begin
		temp_d   = temp_q;
		hum_d    = hum_q;
		light_d  = light_q;
		auto_d   = auto_q;
		lamp_d   = lamp_q;
		toggle_d = 1'b0;
		unique case (cmd.kind)
			KIND_MANUAL: begin
				auto_d   = 1'b0;
				lamp_d   = !lamp_q;
				toggle_d = 1'b1;
			end
			KIND_AUTO: auto_d = 1'b1;
			KIND_ENV: begin
				temp_d  = cmd.temp;
				hum_d   = cmd.hum;
				light_d = cmd.light;
				if (auto_q) begin
					if (cmd.light < dark_th && !lamp_q) begin
						lamp_d   = 1'b1;
						toggle_d = 1'b1;
					end else if (cmd.light > bright_th && lamp_q) begin
						lamp_d   = 1'b0;
						toggle_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q   <= '0;
			hum_q    <= '0;
			light_q  <= '0;
			auto_q   <= 1'b1;
			lamp_q   <= 1'b0;
			valid_q  <= 1'b0;
			kind_q   <= KIND_ENV;
			toggle_q <= 1'b0;
		end else if (pop) begin
			temp_q   <= temp_d;
			hum_q    <= hum_d;
			light_q  <= light_d;
			auto_q   <= auto_d;
			lamp_q   <= lamp_d;
			valid_q  <= 1'b1;
			kind_q   <= cmd.kind;
			toggle_q <= toggle_d;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid   = valid_q;
	assign kind        = kind_q;
	assign temperature = temp_q;
	assign humidity    = hum_q;
	assign light_level = light_q;
	assign lamp_toggle = toggle_q;
	assign night_mode  = lamp_q;
	assign auto_mode   = auto_q;

	a_manual_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == KIND_MANUAL |-> toggle_q && !auto_q)
		else $error("manual toggle result inconsistent");

	a_auto_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == KIND_AUTO |-> !toggle_q && auto_q)
		else $error("auto enable result inconsistent");

	a_env_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == KIND_ENV && toggle_q |-> auto_q)
		else $error("lamp switched outside auto mode");

endmodule

FILE: hw/rtl/framed_sensor_parser_with_hysteresis_core.sv
// ----------------------------------------------------------------------------
// framed_sensor_parser_with_hysteresis_core
// Result path: an accepted request that gives a command enters the queue,
//   then the back pops it once its output register is empty or being read.
// Throughput: one request per cycle while the queue has a free slot; the
//   byte parser handles each byte as it is taken and the two-entry queue
//   absorbs output stalls until it fills.
// Reset (arst_n low, asynchronous): parser idle outside a frame, stored values
//   zero, auto mode on, lamp off, thresholds 20 and 35, queue empty.
// ----------------------------------------------------------------------------
module framed_sensor_parser_with_hysteresis_core import fsph_pkg::*; #(
	parameter int PAYLOAD_MAX = 63
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [7:0]              rx_byte,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              kind,
	output logic signed [VAL_W-1:0] temperature,
	output logic signed [VAL_W-1:0] humidity,
	output logic signed [VAL_W-1:0] light_level,
	output logic                    lamp_toggle,
	output logic                    night_mode,
	output logic                    auto_mode,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [VAL_W-1:0]        cfg_data
);

	logic                    accept;
	logic                    push, pop;
	logic                    q_empty, q_full;
	cmd_t                    front_cmd, back_cmd;
	logic signed [VAL_W-1:0] dark_q, bright_q;

	// A request is taken whenever the queue has a free slot; requests that
	// produce no command (most bytes) update the parser or are dropped.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Threshold registers; the user must write them only while the block is idle, the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q   <= DARK_RESET;
			bright_q <= BRIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DARK:   dark_q   <= cfg_data;
				CFG_BRIGHT: bright_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: framing, ENV payload parse, event classification.
	fsph_front #(
		.PAYLOAD_MAX(PAYLOAD_MAX)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (action),
		.rx_byte (rx_byte),
		.push    (push),
		.cmd     (front_cmd)
	);

	// Decoupling queue.
	fsph_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.rd_cmd (back_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	// Back: value store, hysteresis lamp control, output register.
	fsph_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_avail   (!q_empty),
		.cmd         (back_cmd),
		.pop         (pop),
		.dark_th     (dark_q),
		.bright_th   (bright_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.temperature (temperature),
		.humidity    (humidity),
		.light_level (light_level),
		.lamp_toggle (lamp_toggle),
		.night_mode  (night_mode),
		.auto_mode   (auto_mode)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks framed_sensor_parser_with_hysteresis_core on its own: a short table
// of hand-picked frames and lamp requests, then random frames, broken frames
// and loose events under several threshold settings, each result compared
// against a typed value or an in-bench model of parser and lamp hysteresis.
// ----------------------------------------------------------------------------
module testbench;
	import fsph_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 6;
	localparam int PAYLOAD_KEEP    = 63;
	// quiet cycles before giving up
	localparam int WATCHDOG_LIMIT  = 5000;
	// margin for requests that give no result
	localparam int SETTLE_CYCLES   = 8;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 260;
	localparam int MAX_PRINTED     = 100;

	// action code with no meaning; the block must drop it
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// parser phases past the four prefix positions
	localparam logic [3:0] PH_PRE1  = 4'd4;
	localparam logic [3:0] PH_BODY1 = 4'd5;
	localparam logic [3:0] PH_PRE2  = 4'd6;
	localparam logic [3:0] PH_BODY2 = 4'd7;
	localparam logic [3:0] PH_PRE3  = 4'd8;
	localparam logic [3:0] PH_BODY3 = 4'd9;
	localparam logic [3:0] PH_DONE  = 4'd10;
	localparam logic [3:0] PH_FAIL  = 4'd11;

	localparam logic [7:0] ENV_TAG [4] = '{CH_E, CH_N, CH_V, CH_COMMA};

	typedef struct {
		kind_t                   kind;
		logic signed [VAL_W-1:0] temp;
		logic signed [VAL_W-1:0] hum;
		logic signed [VAL_W-1:0] light;
		logic                    toggle;
		logic                    night;
		logic                    auto_on;
	} sensor_report_t;

	// one row of the directed table: a lone request, or a byte string
	// (text, then pad spaces, then tail) sent as serial bytes
	typedef struct {
		logic [1:0]     act;
		logic [7:0]     lone;
		string          text;
		int             pad;
		string          tail;
		bit             typed;
		sensor_report_t want;
	} stim_row_t;

	// DUT ports
	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [1:0]              action    = ACT_BYTE;
	logic [7:0]              rx_byte   = 8'h00;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              kind;
	logic signed [VAL_W-1:0] temperature;
	logic signed [VAL_W-1:0] humidity;
	logic signed [VAL_W-1:0] light_level;
	logic                    lamp_toggle;
	logic                    night_mode;
	logic                    auto_mode;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_DARK;
	logic [VAL_W-1:0]        cfg_data  = '0;

	// model of the block: thresholds, parser and lamp state
	logic signed [VAL_W-1:0] dark_level;
	logic signed [VAL_W-1:0] bright_level;
	bit                      in_frame;
	int unsigned             kept;
	logic [3:0]              phase;
	bit                      neg;
	bit                      digits;
	int unsigned             mag;
	logic signed [VAL_W-1:0] pend_temp;
	logic signed [VAL_W-1:0] pend_hum;
	logic signed [VAL_W-1:0] cur_temp;
	logic signed [VAL_W-1:0] cur_hum;
	logic signed [VAL_W-1:0] cur_light;
	bit                      auto_on;
	bit                      lamp_lit;

	sensor_report_t reports_due [$];
	stim_row_t      stim_table [$];
	logic [7:0]     frame_bytes [$];
	sensor_report_t no_report;

	int send_idle_pct = 20;
	int recv_idle_pct = 46;
	int errors = 0;
	int requests_sent = 0;
	int directed_sent = 0;
	int results_checked = 0;
	int toggles_seen = 0;
	int quiet_cycles = 0;

	framed_sensor_parser_with_hysteresis_core #(
		.PAYLOAD_MAX (PAYLOAD_KEEP)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.temperature (temperature),
		.humidity    (humidity),
		.light_level (light_level),
		.lamp_toggle (lamp_toggle),
		.night_mode  (night_mode),
		.auto_mode   (auto_mode),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// current number as the parser would store it: negative magnitudes wrap
	// from 32768 to -32768, positive ones clamp at 32767
	function automatic logic signed [VAL_W-1:0] saturated_number();
		if (neg)
			return VAL_W'(32'h10000 - mag);
		if (mag > 32767)
			return 16'sh7FFF;
		return VAL_W'(mag);
	endfunction

	task automatic clear_number();
		neg = 1'b0;
		digits = 1'b0;
		mag = 0;
	endtask

	// advance the model by one request; emitted says whether a result is due
	task automatic parse_and_control(input logic [1:0] act, input logic [7:0] c,
			output bit emitted, output sensor_report_t rep);
		int unsigned grown;
		logic [3:0]  p;
		kind_t       kind_out;
		bit          toggled;
		emitted = 1'b0;
		toggled = 1'b0;
		kind_out = KIND_ENV;
		case (act)
		ACT_TOGGLE: begin
			// manual toggle: auto off, lamp flips, parser untouched
			auto_on = 1'b0;
			lamp_lit = !lamp_lit;
			toggled = 1'b1;
			kind_out = KIND_MANUAL;
			emitted = 1'b1;
		end
		ACT_AUTO: begin
			// no re-evaluation of the stored light value
			auto_on = 1'b1;
			kind_out = KIND_AUTO;
			emitted = 1'b1;
		end
		ACT_BYTE: begin
			if (!in_frame) begin
				// only '$' matters outside a frame
				if (c == CH_DOLLAR) begin
					in_frame = 1'b1;
					kept = 0;
					phase = 4'd0;
					clear_number();
				end
			end else if (c != CH_HASH) begin
				// '$' inside a frame is plain data; bytes past the limit drop
				if (kept < PAYLOAD_KEEP) begin
					kept++;
					p = phase;
					if (p < PH_PRE1) begin
						phase = (c == ENV_TAG[p[1:0]]) ? p + 4'd1 : PH_FAIL;
						if (phase == PH_PRE1)
							clear_number();
					end else if (p == PH_PRE1 || p == PH_PRE2 || p == PH_PRE3) begin
						// leading whitespace is skipped
						if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
							if (c == CH_PLUS || c == CH_MINUS) begin
								neg = (c == CH_MINUS);
								phase = p + 4'd1;
							end else if (c >= CH_ZERO && c <= CH_NINE) begin
								digits = 1'b1;
								mag = c - CH_ZERO;
								phase = p + 4'd1;
							end else begin
								phase = PH_FAIL;
							end
						end
					end else if (p == PH_BODY1 || p == PH_BODY2 || p == PH_BODY3) begin
						if (c >= CH_ZERO && c <= CH_NINE) begin
							grown = mag * 10 + (c - CH_ZERO);
							mag = (grown > 32768) ? 32768 : grown;
							digits = 1'b1;
						end else if (!digits) begin
							phase = PH_FAIL;
						end else if (p == PH_BODY3) begin
							// anything after the third value is ignored
							phase = PH_DONE;
						end else if (c != CH_COMMA) begin
							phase = PH_FAIL;
						end else begin
							if (p == PH_BODY1)
								pend_temp = saturated_number();
							else
								pend_hum = saturated_number();
							phase = p + 4'd1;
							clear_number();
						end
					end
				end
			end else begin
				// '#' closes the frame; malformed frames leave no trace
				in_frame = 1'b0;
				if (phase == PH_DONE || (phase == PH_BODY3 && digits)) begin
					cur_temp = pend_temp;
					cur_hum = pend_hum;
					cur_light = saturated_number();
					// hysteresis: strictly below dark lights, strictly above bright clears
					if (auto_on) begin
						if (cur_light < dark_level && !lamp_lit) begin
							lamp_lit = 1'b1;
							toggled = 1'b1;
						end else if (cur_light > bright_level && lamp_lit) begin
							lamp_lit = 1'b0;
							toggled = 1'b1;
						end
					end
					kind_out = KIND_ENV;
					emitted = 1'b1;
				end
			end
		end
		default: ;
		endcase
		rep = '{kind_out, cur_temp, cur_hum, cur_light, toggled, lamp_lit, auto_on};
	endtask

	// present one request, hold it until taken, then book the expected result
	task automatic send_request(input logic [1:0] act, input logic [7:0] b,
			input bit use_typed, input sensor_report_t typed);
		bit             emitted;
		sensor_report_t rep;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		parse_and_control(act, b, emitted, rep);
		if (emitted) begin
			if (use_typed)
				reports_due.push_back(typed);
			else
				reports_due.push_back(rep);
		end
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_bytes.push_back(s[i]);
	endtask

	function automatic void add_row(input logic [1:0] act, input logic [7:0] lone,
			input string text, input int pad, input string tail,
			input bit typed, input sensor_report_t want);
		stim_row_t r;
		r.act = act;
		r.lone = lone;
		r.text = text;
		r.pad = pad;
		r.tail = tail;
		r.typed = typed;
		r.want = want;
		stim_table.push_back(r);
	endfunction

	// let the queue run dry, then give the pipe time for result-less requests
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_thresholds(input logic signed [VAL_W-1:0] dark,
			input logic signed [VAL_W-1:0] bright);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DARK;
		cfg_data <= dark;
		@(negedge clk);
		cfg_index <= CFG_BRIGHT;
		cfg_data <= bright;
		@(negedge clk);
		cfg_we <= 1'b0;
		dark_level = dark;
		bright_level = bright;
		@(negedge clk);
	endtask

	// random traffic: mostly well-formed env frames with random numbers,
	// some damaged or cut short, some past the payload limit, some loose events
	task automatic run_random(input int target);
		int          sent;
		int          r;
		int          ws;
		int          pos;
		int          want_len;
		int unsigned num;
		logic [7:0]  tb;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r >= 86) begin
				case ($urandom_range(0, 9))
				0, 1, 2: send_request(ACT_TOGGLE, 8'($urandom), 1'b0, no_report);
				3, 4, 5: send_request(ACT_AUTO, 8'($urandom), 1'b0, no_report);
				6:       send_request(ACT_SPARE, 8'($urandom), 1'b0, no_report);
				default: send_request(ACT_BYTE, 8'($urandom), 1'b0, no_report);
				endcase
				sent++;
			end else begin
				frame_bytes.delete();
				frame_bytes.push_back(CH_DOLLAR);
				push_text("ENV,");
				for (int k = 0; k < 3; k++) begin
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 2)) begin
							ws = $urandom_range(0, 5);
							frame_bytes.push_back(ws == 0 ? CH_SPACE : 8'(CH_TAB + ws - 1));
						end
					end
					case ($urandom_range(0, 3))
					0:       frame_bytes.push_back(CH_PLUS);
					1:       frame_bytes.push_back(CH_MINUS);
					default: ;
					endcase
					// small values sit around the thresholds, big ones saturate
					ws = $urandom_range(0, 99);
					if (ws < 60)
						num = $urandom_range(0, 60);
					else if (ws < 85)
						num = $urandom_range(0, 40000);
					else
						num = $urandom_range(0, 99999999);
					if ($urandom_range(0, 7) == 0)
						push_text("00");
					push_text($sformatf("%0d", num));
					if (k < 2)
						frame_bytes.push_back(CH_COMMA);
				end
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 4)) begin
						tb = 8'($urandom);
						frame_bytes.push_back(tb == CH_HASH ? CH_COMMA : tb);
					end
				end
				frame_bytes.push_back(CH_HASH);
				if (r >= 62 && r < 80) begin
					if ($urandom_range(0, 2) == 0) begin
						// cut short and closed early
						pos = $urandom_range(2, frame_bytes.size() - 1);
						while (frame_bytes.size() > pos)
							void'(frame_bytes.pop_back());
						frame_bytes.push_back(CH_HASH);
					end else begin
						// corrupt a byte or two, possibly into '$' or '#'
						repeat ($urandom_range(1, 2)) begin
							pos = $urandom_range(1, frame_bytes.size() - 2);
							frame_bytes[pos] = 8'($urandom);
						end
					end
				end else if (r >= 80) begin
					// pad to either side of the payload limit
					want_len = $urandom_range(PAYLOAD_KEEP - 5, PAYLOAD_KEEP + 12);
					void'(frame_bytes.pop_back());
					while (frame_bytes.size() - 1 < want_len)
						frame_bytes.push_back(CH_SPACE);
					frame_bytes.push_back(CH_HASH);
				end
				foreach (frame_bytes[i])
					send_request(ACT_BYTE, frame_bytes[i], 1'b0, no_report);
				sent += frame_bytes.size();
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MAX_PRINTED)
			$display("mismatch at result %0d, %s: got %0d, want %0d",
				results_checked, what, got, want);
		errors++;
	endtask

	// receiver: random back-pressure, changed on the falling edge
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// result checker: oldest expectation against each result taken
	always @(posedge clk) begin : check_results
		sensor_report_t e;
		if (arst_n && out_valid && out_ready) begin
			if (reports_due.size() == 0) begin
				report_mismatch("result with nothing pending, kind", kind, 0);
			end else begin
				e = reports_due.pop_front();
				if (kind !== e.kind)
					report_mismatch("kind", kind, e.kind);
				if (temperature !== e.temp)
					report_mismatch("temperature", temperature, e.temp);
				if (humidity !== e.hum)
					report_mismatch("humidity", humidity, e.hum);
				if (light_level !== e.light)
					report_mismatch("light_level", light_level, e.light);
				if (lamp_toggle !== e.toggle)
					report_mismatch("lamp_toggle", lamp_toggle, e.toggle);
				if (night_mode !== e.night)
					report_mismatch("night_mode", night_mode, e.night);
				if (auto_mode !== e.auto_on)
					report_mismatch("auto_mode", auto_mode, e.auto_on);
				if (e.toggle)
					toggles_seen++;
				results_checked++;
			end
		end
	end

	// watchdog: any request or result taken resets the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int lo;
		// model state after reset
		dark_level = DARK_RESET;
		bright_level = BRIGHT_RESET;
		in_frame = 1'b0;
		kept = 0;
		phase = 4'd0;
		clear_number();
		pend_temp = '0;
		pend_hum = '0;
		cur_temp = '0;
		cur_hum = '0;
		cur_light = '0;
		auto_on = 1'b1;
		lamp_lit = 1'b0;

		// directed table; typed rows carry a result readable at a glance,
		// the rest are checked against the model
		add_row(ACT_AUTO, 8'h00, "", 0, "", 1'b1,
			'{KIND_AUTO, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1});
		add_row(ACT_SPARE, 8'hFF, "", 0, "", 1'b0, no_report);
		// loose bytes outside a frame, both byte extremes
		add_row(ACT_BYTE, 8'hFF, "", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "", 0, "", 1'b0, no_report);
		// dark light in auto mode lights the lamp
		add_row(ACT_BYTE, 8'h00, "$ENV,1,2,3#", 0, "", 1'b1,
			'{KIND_ENV, 16'sd1, 16'sd2, 16'sd3, 1'b1, 1'b1, 1'b1});
		add_row(ACT_TOGGLE, 8'hFF, "", 0, "", 1'b1,
			'{KIND_MANUAL, 16'sd1, 16'sd2, 16'sd3, 1'b1, 1'b0, 1'b0});
		// saturation both ways, manual mode so no lamp change
		add_row(ACT_BYTE, 8'h00, "$ENV,99999,-99999,40000#", 0, "", 1'b1,
			'{KIND_ENV, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 1'b0});
		add_row(ACT_TOGGLE, 8'h00, "", 0, "", 1'b1,
			'{KIND_MANUAL, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 1'b0});
		// enable auto does not look at the stored light
		add_row(ACT_AUTO, 8'hFF, "", 0, "", 1'b1,
			'{KIND_AUTO, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1'b1});
		add_row(ACT_BYTE, 8'h00, "$ENV,-32768,32768,-0#", 0, "", 1'b1,
			'{KIND_ENV, 16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, 1'b1, 1'b1});
		// whitespace, explicit signs, trailing text
		add_row(ACT_BYTE, 8'h00, "$ENV,  -5,\t+7,\n12xyz#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,1,2,50#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "abc#", 0, "", 1'b0, no_report);
		// malformed frames: empty value, bare sign, bad prefix, bad separator,
		// missing third value, bare third sign, empty payload
		add_row(ACT_BYTE, 8'h00, "$ENV,1,,3#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,-,2,3#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$XNV,1,2,3#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,1;2,3#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,1,2,#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,1,2,-#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$#", 0, "", 1'b0, no_report);
		// '$' inside a payload is data
		add_row(ACT_BYTE, 8'h00, "$$ENV,1,2,3#", 0, "", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,4,5,6$#", 0, "", 1'b0, no_report);
		// overlong: good frame kept, then a frame whose last digit is dropped
		add_row(ACT_BYTE, 8'h00, "$ENV,7,8,9", 60, "#", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,1,2,", 55, "5#", 1'b0, no_report);
		add_row(ACT_BYTE, 8'h00, "$ENV,00000000012,+0,-1#", 0, "", 1'b0, no_report);

		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[n]) begin
			if (stim_table[n].text.len() == 0) begin
				send_request(stim_table[n].act, stim_table[n].lone,
					stim_table[n].typed, stim_table[n].want);
			end else begin
				frame_bytes.delete();
				push_text(stim_table[n].text);
				repeat (stim_table[n].pad)
					frame_bytes.push_back(CH_SPACE);
				push_text(stim_table[n].tail);
				// only the closing '#' can give a result, so the typed
				// expectation rides on every byte of the row
				foreach (frame_bytes[i])
					send_request(ACT_BYTE, frame_bytes[i],
						stim_table[n].typed, stim_table[n].want);
			end
		end
		directed_sent = requests_sent;

		// random phases: idle profile moves from sender-light to
		// receiver-light to none; thresholds change only while idle
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 46 : 0;
			recv_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 20 : 0;
			if (ph > 0) begin
				wait_idle();
				case (ph)
				1: set_thresholds(16'sh8000, 16'sh7FFF);
				2: set_thresholds(16'sh7FFF, 16'sh8000);
				3: begin
					lo = int'($urandom_range(0, 80)) - 40;
					set_thresholds(VAL_W'(lo), VAL_W'(lo + int'($urandom_range(0, 40))));
				end
				4: set_thresholds(DARK_RESET, BRIGHT_RESET);
				default: set_thresholds(VAL_W'(int'($urandom_range(0, 120)) - 60),
					VAL_W'(int'($urandom_range(0, 120)) - 60));
				endcase
			end
			run_random(ITEMS_PER_PHASE);
		end

		wait_idle();
		$display("covered %0d requests (%0d from the directed table) over %0d threshold phases",
			requests_sent, directed_sent, NUM_PHASES);
		$display("%0d results checked, %0d lamp toggles among them, %0d mismatches",
			results_checked, toggles_seen, errors);
		if (errors == 0 && reports_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
